>>> rtl/core/rti_pkg.sv
package rti_pkg;

  // default geometry of the datapath
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // multiplier operand slice, one partial product per slice
  localparam int MUL_CHUNK = 32;

  // configuration register map
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_ORIGIN_Z,
    CFG_DIR_X,
    CFG_DIR_Y,
    CFG_DIR_Z,
    CFG_TOLERANCE
  } cfg_reg_t;

  // control that travels alongside the datapath
  typedef struct packed {
    logic valid;
    logic miss;
  } stage_ctl_t;

endpackage

>>> rtl/core/rti_if.sv
interface rti_in_if import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] v0_x, v0_y, v0_z;
  logic signed [COORD_WIDTH-1:0] v1_x, v1_y, v1_z;
  logic signed [COORD_WIDTH-1:0] v2_x, v2_y, v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                output ready);
endinterface

interface rti_out_if import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] hit_distance;
  logic signed [FRAC_BITS+2:0]   bary_w0;
  logic signed [FRAC_BITS+1:0]   bary_u;
  logic signed [FRAC_BITS+1:0]   bary_v;
  logic signed [COORD_WIDTH-1:0] hit_x, hit_y, hit_z;

  modport source (output valid, hit, hit_distance, bary_w0, bary_u, bary_v,
                  hit_x, hit_y, hit_z, input ready);
  modport sink (input valid, hit, hit_distance, bary_w0, bary_u, bary_v,
                hit_x, hit_y, hit_z, output ready);
endinterface

interface rti_cfg_if import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [COORD_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/rti_mul.sv
module rti_mul import rti_pkg::*; #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NC  = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int PPW = WA + MUL_CHUNK + 1;
  localparam int PW  = WA + WB;

  logic signed [PPW-1:0] pp_r [NC];
  logic signed [PW-1:0]  p_r, p_nxt;

  // first stage: one partial product per slice of b
  for (genvar j = 0; j < NC; j++) begin : g_pp
    logic signed [MUL_CHUNK:0] chunk;
    logic signed [PPW-1:0]     prod;
    if (j < NC - 1) begin : g_lo
      assign chunk = {1'b0, b[j*MUL_CHUNK +: MUL_CHUNK]};
    end else begin : g_hi
      localparam int TOPW = WB - j * MUL_CHUNK;
      assign chunk = (MUL_CHUNK+1)'($signed(b[WB-1 -: TOPW]));
    end
    assign prod = a * chunk;
    always_ff @(posedge clk) begin
      if (en) begin
        pp_r[j] <= prod;
      end
    end
  end

  // second stage: align and add the partial products
  always_comb begin
    p_nxt = '0;
    for (int c = 0; c < NC; c++) begin
      p_nxt = p_nxt + (PW'(pp_r[c]) <<< (c * MUL_CHUNK));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

>>> rtl/core/rti_div.sv
module rti_div import rti_pkg::*; #(
  parameter int NW = 102,
  parameter int F  = 16,
  parameter int QB = 49
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  stage_ctl_t           ctl_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [NW-1:0] den_i,
  output stage_ctl_t           ctl_o,
  output logic signed [QB:0]   quo_o
);

  // quotient is (num << F) / den, magnitude kept to QB bits, larger clamps to all ones
  localparam int XW = NW + F;
  localparam int HW = XW - QB;

  // magnitudes and sign
  stage_ctl_t    ctl0_r;
  logic [NW-1:0] an_r, dn_r;
  logic          neg0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (en) begin
      ctl0_r.valid <= ctl_i.valid;
      ctl0_r.miss  <= ctl_i.miss | (den_i == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an_r   <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      dn_r   <= den_i[NW-1] ? NW'(-den_i) : NW'(den_i);
      neg0_r <= num_i[NW-1] ^ den_i[NW-1];
    end
  end

  // stage arrays: index 0 holds the setup, index k the state after k quotient bits
  stage_ctl_t    ctl_r   [QB+1];
  logic [NW-1:0] rem_r   [QB+1];
  logic [NW-1:0] den_r   [QB+1];
  logic [QB-1:0] lo_r    [QB+1];
  logic [QB-1:0] quo_r   [QB+1];
  logic          neg_r   [QB+1];
  logic          clamp_r [QB+1];

  // setup: top of the dividend, overflow check
  logic [XW-1:0] x_w;
  logic [HW-1:0] hi_w;
  logic          clamp_w;

  assign x_w     = {an_r, {F{1'b0}}};
  assign hi_w    = x_w[XW-1:QB];
  assign clamp_w = NW'(hi_w) >= dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]   <= clamp_w ? '0 : NW'(hi_w);
      den_r[0]   <= dn_r;
      lo_r[0]    <= x_w[QB-1:0];
      quo_r[0]   <= '0;
      neg_r[0]   <= neg0_r;
      clamp_r[0] <= clamp_w;
    end
  end

  // one restoring step per stage
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [NW:0]   trial;
    logic [NW:0]   diff;
    logic          ge;
    logic [NW-1:0] rem_nxt;

    assign trial   = {rem_r[k-1], lo_r[k-1][QB-1]};
    assign diff    = trial - {1'b0, den_r[k-1]};
    assign ge      = trial >= {1'b0, den_r[k-1]};
    assign rem_nxt = ge ? diff[NW-1:0] : trial[NW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else if (en) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]   <= rem_nxt;
        den_r[k]   <= den_r[k-1];
        lo_r[k]    <= lo_r[k-1] << 1;
        quo_r[k]   <= {quo_r[k-1][QB-2:0], ge};
        neg_r[k]   <= neg_r[k-1];
        clamp_r[k] <= clamp_r[k-1];
      end
    end
  end

  // signed result
  logic [QB-1:0] mag;

  assign mag   = clamp_r[QB] ? '1 : quo_r[QB];
  assign quo_o = neg_r[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign ctl_o = ctl_r[QB];

endmodule

>>> rtl/core/ray_triangle_intersection_unit.sv
// Moller-Trumbore ray/triangle test, one ray in registers against a triangle stream.
// The three long dividers compute one quotient bit per stage.
// Throughput: one triangle per cycle; the whole pipeline holds only while the result
// register is full and not taken, and moves whenever its last stage is empty.
// Reset (rst_n low, synchronous) clears ray registers to zero and all valid bits.
module ray_triangle_intersection_unit import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rti_cfg_if.sink   cfg_ch,
  rti_in_if.sink    in_ch,
  rti_out_if.source out_ch
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int EW  = W + 1;          // edge, offset
  localparam int M1W = 2 * EW;         // first level product
  localparam int PQW = M1W + 1;        // p and q vectors
  localparam int M2W = EW + PQW;       // second level product
  localparam int NW  = M2W + 2;        // determinant, numerators
  localparam int QB  = W + F + 1;      // quotient magnitude bits
  localparam int TW  = QB + 1;         // signed quotient
  localparam int M3W = W + TW;         // t times direction
  localparam int HPW = M3W - F + 1;    // hit point before saturation
  localparam int W0W = F + 3;
  localparam int UVW = F + 2;

  // ray registers
  logic signed [W-1:0] org_r [3];
  logic signed [W-1:0] dir_r [3];
  logic [F-1:0]        tol_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
      end
      tol_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ORIGIN_X:  org_r[0] <= cfg_ch.data;
        CFG_ORIGIN_Y:  org_r[1] <= cfg_ch.data;
        CFG_ORIGIN_Z:  org_r[2] <= cfg_ch.data;
        CFG_DIR_X:     dir_r[0] <= cfg_ch.data;
        CFG_DIR_Y:     dir_r[1] <= cfg_ch.data;
        CFG_DIR_Z:     dir_r[2] <= cfg_ch.data;
        CFG_TOLERANCE: tol_r    <= cfg_ch.data[F-1:0];
        default: ;
      endcase
    end
  end

  logic signed [EW-1:0] dir_e [3];
  for (genvar i = 0; i < 3; i++) begin : g_dir
    assign dir_e[i] = EW'(dir_r[i]);
  end

  // pipeline advance
  logic out_vld_r, out_load, pipe_en;
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, f_vld_r, g_vld_r;
  logic h_vld_r, i_vld_r, j_vld_r;

  assign out_load    = !out_vld_r || out_ch.ready;
  assign pipe_en     = !j_vld_r || out_load;
  assign in_ch.ready = pipe_en;

  stage_ctl_t ctl_g, ctl_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
    end else if (pipe_en) begin
      a_vld_r <= in_ch.valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
      h_vld_r <= ctl_t.valid;
      i_vld_r <= h_vld_r;
      j_vld_r <= i_vld_r;
    end
  end

  // stage A: edges and origin offset
  logic signed [W-1:0] v0 [3];
  logic signed [W-1:0] v1 [3];
  logic signed [W-1:0] v2 [3];

  assign v0[0] = in_ch.v0_x;
  assign v0[1] = in_ch.v0_y;
  assign v0[2] = in_ch.v0_z;
  assign v1[0] = in_ch.v1_x;
  assign v1[1] = in_ch.v1_y;
  assign v1[2] = in_ch.v1_z;
  assign v2[0] = in_ch.v2_x;
  assign v2[1] = in_ch.v2_y;
  assign v2[2] = in_ch.v2_z;

  logic signed [EW-1:0] e1_a_r [3], e2_a_r [3], s_a_r [3];
  logic signed [EW-1:0] e1_b_r [3], e2_b_r [3], s_b_r [3];
  logic signed [EW-1:0] e1_c_r [3], e2_c_r [3], s_c_r [3];
  logic signed [EW-1:0] e1_d_r [3], e2_d_r [3], s_d_r [3];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        e1_a_r[i] <= EW'(v1[i]) - EW'(v0[i]);
        e2_a_r[i] <= EW'(v2[i]) - EW'(v0[i]);
        s_a_r[i]  <= EW'(org_r[i]) - EW'(v0[i]);
        e1_b_r[i] <= e1_a_r[i];
        e2_b_r[i] <= e2_a_r[i];
        s_b_r[i]  <= s_a_r[i];
        e1_c_r[i] <= e1_b_r[i];
        e2_c_r[i] <= e2_b_r[i];
        s_c_r[i]  <= s_b_r[i];
        e1_d_r[i] <= e1_c_r[i];
        e2_d_r[i] <= e2_c_r[i];
        s_d_r[i]  <= s_c_r[i];
      end
    end
  end

  // stages B, C: cross product terms p = dir x e2, q = s x e1
  logic signed [M1W-1:0] pa [3], pb [3], qa [3], qb [3];

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    rti_mul #(.WA(EW), .WB(EW)) u_pa (
      .clk(clk), .en(pipe_en), .a(dir_e[J]), .b(e2_a_r[K]), .p(pa[i]));
    rti_mul #(.WA(EW), .WB(EW)) u_pb (
      .clk(clk), .en(pipe_en), .a(dir_e[K]), .b(e2_a_r[J]), .p(pb[i]));
    rti_mul #(.WA(EW), .WB(EW)) u_qa (
      .clk(clk), .en(pipe_en), .a(s_a_r[J]), .b(e1_a_r[K]), .p(qa[i]));
    rti_mul #(.WA(EW), .WB(EW)) u_qb (
      .clk(clk), .en(pipe_en), .a(s_a_r[K]), .b(e1_a_r[J]), .p(qb[i]));
  end

  // stage D: cross products
  logic signed [PQW-1:0] p_d_r [3], q_d_r [3];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        p_d_r[i] <= PQW'(pa[i]) - PQW'(pb[i]);
        q_d_r[i] <= PQW'(qa[i]) - PQW'(qb[i]);
      end
    end
  end

  // stages E, F: dot product terms
  logic signed [M2W-1:0] md [3], mu [3], mv [3], mt [3];

  for (genvar i = 0; i < 3; i++) begin : g_dot
    rti_mul #(.WA(EW), .WB(PQW)) u_det (
      .clk(clk), .en(pipe_en), .a(e1_d_r[i]), .b(p_d_r[i]), .p(md[i]));
    rti_mul #(.WA(EW), .WB(PQW)) u_nu (
      .clk(clk), .en(pipe_en), .a(s_d_r[i]), .b(p_d_r[i]), .p(mu[i]));
    rti_mul #(.WA(EW), .WB(PQW)) u_nv (
      .clk(clk), .en(pipe_en), .a(dir_e[i]), .b(q_d_r[i]), .p(mv[i]));
    rti_mul #(.WA(EW), .WB(PQW)) u_nt (
      .clk(clk), .en(pipe_en), .a(e2_d_r[i]), .b(q_d_r[i]), .p(mt[i]));
  end

  // stage G: determinant and numerators
  logic signed [NW-1:0] det_g_r, nu_g_r, nv_g_r, nt_g_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      det_g_r <= NW'(md[0]) + NW'(md[1]) + NW'(md[2]);
      nu_g_r  <= NW'(mu[0]) + NW'(mu[1]) + NW'(mu[2]);
      nv_g_r  <= NW'(mv[0]) + NW'(mv[1]) + NW'(mv[2]);
      nt_g_r  <= NW'(mt[0]) + NW'(mt[1]) + NW'(mt[2]);
    end
  end

  // quotients u, v, t
  assign ctl_g.valid = g_vld_r;
  assign ctl_g.miss  = 1'b0;

  logic signed [TW-1:0] u_q, v_q, t_q;

  rti_div #(.NW(NW), .F(F), .QB(QB)) u_div_u (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .ctl_i(ctl_g),
    .num_i(nu_g_r), .den_i(det_g_r), .ctl_o(), .quo_o(u_q));
  rti_div #(.NW(NW), .F(F), .QB(QB)) u_div_v (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .ctl_i(ctl_g),
    .num_i(nv_g_r), .den_i(det_g_r), .ctl_o(), .quo_o(v_q));
  rti_div #(.NW(NW), .F(F), .QB(QB)) u_div_t (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .ctl_i(ctl_g),
    .num_i(nt_g_r), .den_i(det_g_r), .ctl_o(ctl_t), .quo_o(t_q));

  // stage H: bounds tests and saturated fields
  logic signed [TW-1:0]  eps_s, meps_s, one_s, upper_s;
  logic signed [TW:0]    uv_s;
  logic signed [TW+1:0]  w0_full;
  logic                  miss_h;

  assign eps_s   = TW'(tol_r);
  assign meps_s  = -eps_s;
  assign one_s   = TW'(1) << F;
  assign upper_s = one_s + eps_s;
  assign uv_s    = (TW+1)'(u_q) + (TW+1)'(v_q);
  assign w0_full = (TW+2)'(one_s) - (TW+2)'(u_q) - (TW+2)'(v_q);
  assign miss_h  = ctl_t.miss || (u_q < meps_s) || (u_q > upper_s) || (v_q < meps_s) ||
                   (uv_s > (TW+1)'(upper_s)) || (t_q < meps_s);

  logic signed [TW-1:0]  t_top, u_top, v_top;
  logic signed [TW+1:0]  w0_top;
  logic [W-1:0]          t_sat;
  logic [UVW-1:0]        u_sat, v_sat;
  logic [W0W-1:0]        w0_sat;

  assign t_top  = t_q >>> (W - 1);
  assign u_top  = u_q >>> (UVW - 1);
  assign v_top  = v_q >>> (UVW - 1);
  assign w0_top = w0_full >>> (W0W - 1);

  assign t_sat  = (t_top == '0 || t_top == '1) ? t_q[W-1:0] :
                  {t_q[TW-1], {(W-1){~t_q[TW-1]}}};
  assign u_sat  = (u_top == '0 || u_top == '1) ? u_q[UVW-1:0] :
                  {u_q[TW-1], {(UVW-1){~u_q[TW-1]}}};
  assign v_sat  = (v_top == '0 || v_top == '1) ? v_q[UVW-1:0] :
                  {v_q[TW-1], {(UVW-1){~v_q[TW-1]}}};
  assign w0_sat = (w0_top == '0 || w0_top == '1) ? w0_full[W0W-1:0] :
                  {w0_full[TW+1], {(W0W-1){~w0_full[TW+1]}}};

  logic                 h_hit_r, i_hit_r, j_hit_r;
  logic [W-1:0]         h_dist_r, i_dist_r, j_dist_r;
  logic [W0W-1:0]       h_w0_r, i_w0_r, j_w0_r;
  logic [UVW-1:0]       h_u_r, i_u_r, j_u_r;
  logic [UVW-1:0]       h_v_r, i_v_r, j_v_r;
  logic signed [TW-1:0] h_t_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      h_hit_r  <= !miss_h;
      h_dist_r <= miss_h ? '0 : t_sat;
      h_w0_r   <= miss_h ? '0 : w0_sat;
      h_u_r    <= miss_h ? '0 : u_sat;
      h_v_r    <= miss_h ? '0 : v_sat;
      h_t_r    <= miss_h ? '0 : t_q;
      i_hit_r  <= h_hit_r;
      i_dist_r <= h_dist_r;
      i_w0_r   <= h_w0_r;
      i_u_r    <= h_u_r;
      i_v_r    <= h_v_r;
      j_hit_r  <= i_hit_r;
      j_dist_r <= i_dist_r;
      j_w0_r   <= i_w0_r;
      j_u_r    <= i_u_r;
      j_v_r    <= i_v_r;
    end
  end

  // stages I, J: t times direction
  logic signed [M3W-1:0] hp_prod [3];
  logic signed [HPW-1:0] hp_sum [3];
  logic signed [HPW-1:0] hp_top [3];
  logic [W-1:0]          hp_sat [3];

  for (genvar i = 0; i < 3; i++) begin : g_hit
    rti_mul #(.WA(W), .WB(TW)) u_hp (
      .clk(clk), .en(pipe_en), .a(dir_r[i]), .b(h_t_r), .p(hp_prod[i]));
    assign hp_sum[i] = HPW'(hp_prod[i] >>> F) + HPW'(org_r[i]);
    assign hp_top[i] = hp_sum[i] >>> (W - 1);
    assign hp_sat[i] = (hp_top[i] == '0 || hp_top[i] == '1) ? hp_sum[i][W-1:0] :
                       {hp_sum[i][HPW-1], {(W-1){~hp_sum[i][HPW-1]}}};
  end

  // result register
  logic           out_hit_r;
  logic [W-1:0]   out_dist_r;
  logic [W0W-1:0] out_w0_r;
  logic [UVW-1:0] out_u_r, out_v_r;
  logic [W-1:0]   out_hp_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= j_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && j_vld_r) begin
      out_hit_r  <= j_hit_r;
      out_dist_r <= j_dist_r;
      out_w0_r   <= j_w0_r;
      out_u_r    <= j_u_r;
      out_v_r    <= j_v_r;
      for (int i = 0; i < 3; i++) begin
        out_hp_r[i] <= j_hit_r ? hp_sat[i] : '0;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.hit_distance = out_dist_r;
  assign out_ch.bary_w0      = out_w0_r;
  assign out_ch.bary_u       = out_u_r;
  assign out_ch.bary_v       = out_v_r;
  assign out_ch.hit_x        = out_hp_r[0];
  assign out_ch.hit_y        = out_hp_r[1];
  assign out_ch.hit_z        = out_hp_r[2];

`ifndef NO_ASSERTIONS
  logic signed [W:0] dist_plus_tol;
  assign dist_plus_tol = (W+1)'(out_ch.hit_distance) + (W+1)'(tol_r);

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.hit) |->
      (out_ch.hit_distance == '0 && out_ch.bary_w0 == '0 && out_ch.bary_u == '0 &&
       out_ch.bary_v == '0 && out_ch.hit_x == '0 && out_ch.hit_y == '0 &&
       out_ch.hit_z == '0))
    else $error("miss result with nonzero fields");

  // a hit never lies further behind the origin than the tolerance
  a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.hit) |-> dist_plus_tol >= 0)
    else $error("hit distance below minus tolerance");

  // input is held back only by a full, untaken result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output back-pressure");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import rti_pkg::*;

  localparam int CW        = COORD_WIDTH_DEF;
  localparam int FB        = FRAC_BITS_DEF;
  localparam int Q_ONE     = 1 << FB;
  localparam int IDLE_MAX  = 6000;  // cycles without any beat before giving up
  localparam int DRAIN_CYC = 70;    // pipeline depth plus margin
  localparam int N_RAND    = 1500;
  localparam int N_PHASES  = 9;

  typedef logic signed [255:0]  big_t;
  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t               tri_t [9];

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] distance;
    logic signed [FB+2:0] w0;
    logic signed [FB+1:0] u;
    logic signed [FB+1:0] v;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
  } isect_t;

  logic clk;
  logic rst_n;

  rti_cfg_if #(.COORD_WIDTH(CW))                 cfg_ch ();
  rti_in_if  #(.COORD_WIDTH(CW))                 in_ch ();
  rti_out_if #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) out_ch ();

  ray_triangle_intersection_unit #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow of the ray registers
  coord_t      ray_org [3];
  coord_t      ray_dir [3];
  logic [FB-1:0] ray_tol;

  isect_t pending_isects [$];
  int     n_mismatch;
  int     n_orphan;
  int     n_results;
  int     n_hits;
  int     n_sent;
  int     idle_cycles;
  bit     tx_busy_gaps;
  bit     rx_busy_gaps;
  bit     held_once;
  int     stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // clamp to an n-bit signed range
  function automatic big_t clamp_to(big_t x, int n);
    big_t hi, lo;
    hi = (big_t'(1) <<< (n - 1)) - 1;
    lo = -hi - 1;
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // exact Moller-Trumbore in wide signed arithmetic
  function automatic isect_t trace_ray(tri_t tv);
    big_t o [3], d [3], e1 [3], e2 [3], s [3], p [3], q [3];
    big_t det, bu, bv, bt, eps, one_q, upper, hp, c;
    isect_t r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      o[i]  = big_t'(ray_org[i]);
      d[i]  = big_t'(ray_dir[i]);
      e1[i] = big_t'(tv[3+i]) - big_t'(tv[i]);
      e2[i] = big_t'(tv[6+i]) - big_t'(tv[i]);
      s[i]  = o[i] - big_t'(tv[i]);
    end
    eps   = $signed({240'd0, ray_tol});
    one_q = big_t'(Q_ONE);
    upper = one_q + eps;
    p[0] = d[1] * e2[2] - d[2] * e2[1];
    p[1] = d[2] * e2[0] - d[0] * e2[2];
    p[2] = d[0] * e2[1] - d[1] * e2[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    if (det == 0) return r;
    bu = ((s[0] * p[0] + s[1] * p[1] + s[2] * p[2]) <<< FB) / det;
    if (bu < -eps || bu > upper) return r;
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    bv = ((d[0] * q[0] + d[1] * q[1] + d[2] * q[2]) <<< FB) / det;
    if (bv < -eps || bu + bv > upper) return r;
    bt = ((e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2]) <<< FB) / det;
    if (bt < -eps) return r;
    r.hit = 1'b1;
    c = clamp_to(bt, CW);               r.distance = c[CW-1:0];
    c = clamp_to(one_q - bu - bv, FB+3); r.w0   = c[FB+2:0];
    c = clamp_to(bu, FB+2);             r.u    = c[FB+1:0];
    c = clamp_to(bv, FB+2);             r.v    = c[FB+1:0];
    hp = o[0] + ((bt * d[0]) >>> FB); c = clamp_to(hp, CW); r.px = c[CW-1:0];
    hp = o[1] + ((bt * d[1]) >>> FB); c = clamp_to(hp, CW); r.py = c[CW-1:0];
    hp = o[2] + ((bt * d[2]) >>> FB); c = clamp_to(hp, CW); r.pz = c[CW-1:0];
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // one register write; valid stays high for back-to-back writes
  task automatic cfg_write(cfg_reg_t idx, logic [CW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_ORIGIN_X:  ray_org[0] = val;
      CFG_ORIGIN_Y:  ray_org[1] = val;
      CFG_ORIGIN_Z:  ray_org[2] = val;
      CFG_DIR_X:     ray_dir[0] = val;
      CFG_DIR_Y:     ray_dir[1] = val;
      CFG_DIR_Z:     ray_dir[2] = val;
      CFG_TOLERANCE: ray_tol    = val[FB-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_ray(coord_t ox, coord_t oy, coord_t oz,
                          coord_t dx, coord_t dy, coord_t dz, logic [CW-1:0] tol);
    cfg_write(CFG_ORIGIN_X, ox);
    cfg_write(CFG_ORIGIN_Y, oy);
    cfg_write(CFG_ORIGIN_Z, oz);
    cfg_write(CFG_DIR_X, dx);
    cfg_write(CFG_DIR_Y, dy);
    cfg_write(CFG_DIR_Z, dz);
    cfg_write(CFG_TOLERANCE, tol);
    cfg_ch.valid <= 1'b0;
  endtask

  // offer one triangle; the expectation is queued at its beat
  task automatic send_tri(tri_t tv, bit typed_miss);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.v0_x <= tv[0]; in_ch.v0_y <= tv[1]; in_ch.v0_z <= tv[2];
    in_ch.v1_x <= tv[3]; in_ch.v1_y <= tv[4]; in_ch.v1_z <= tv[5];
    in_ch.v2_x <= tv[6]; in_ch.v2_y <= tv[7]; in_ch.v2_z <= tv[8];
    do @(negedge clk); while (!in_ch.ready);
    pending_isects.push_back(typed_miss ? isect_t'('0) : trace_ray(tv));
    n_sent++;
    @(posedge clk);
    gap = tx_busy_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let every result come back before touching the registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_isects.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // random triangle: mostly placed around the ray, some noise and degenerates
  task automatic make_tri(output tri_t tv);
    int kind, k;
    coord_t ctr;
    kind = $urandom_range(0, 99);
    k = $urandom_range(0, 12) - 2;
    for (int i = 0; i < 9; i++) begin
      if (kind < 75) begin
        ctr = ray_org[i % 3] + k * ray_dir[i % 3];
        tv[i] = ctr + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      end else begin
        tv[i] = $urandom;
      end
    end
    // degenerate: collapse an edge
    if (kind >= 92)
      for (int i = 0; i < 3; i++) tv[3+i] = tv[i];
  endtask

  // receive side: random back-pressure plus one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!held_once && n_results >= 200) begin
      held_once    <= 1'b1;
      out_ch.ready <= 1'b0;
      stall_left   <= 400;
    end else if (!rx_busy_gaps) begin
      out_ch.ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  out_ch.ready <= 1'b1;
        [70:96]: out_ch.ready <= 1'b0;
        default: begin
          out_ch.ready <= 1'b0;
          stall_left   <= $urandom_range(10, 60);
        end
      endcase
    end
  end

  // compare each result beat against the oldest expectation
  always @(negedge clk) begin
    isect_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.hit, out_ch.hit_distance, out_ch.bary_w0, out_ch.bary_u,
              out_ch.bary_v, out_ch.hit_x, out_ch.hit_y, out_ch.hit_z};
      n_results++;
      if (pending_isects.size() == 0) begin
        n_orphan++;
        $display("ERROR: result beat with nothing expected at %0t", $realtime);
      end else begin
        want = pending_isects.pop_front();
        if (want.hit) n_hits++;
        if (got.hit != want.hit || got.distance != want.distance || got.w0 != want.w0 ||
            got.u != want.u || got.v != want.v || got.px != want.px ||
            got.py != want.py || got.pz != want.pz) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("ERROR: result %0d mismatch at %0t", n_results, $realtime);
            $display("  exp hit=%0d t=%0d w0=%0d u=%0d v=%0d p=(%0d,%0d,%0d)",
                     want.hit, want.distance, want.w0, want.u, want.v,
                     want.px, want.py, want.pz);
            $display("  got hit=%0d t=%0d w0=%0d u=%0d v=%0d p=(%0d,%0d,%0d)",
                     got.hit, got.distance, got.w0, got.u, got.v,
                     got.px, got.py, got.pz);
          end
        end
      end
    end
  end

  // watchdog on beats of any channel
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
        $display("ERROR: no beat for %0d cycles, %0d results outstanding",
                 IDLE_MAX, pending_isects.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  localparam coord_t QMAX = 32'sh7FFF_FFFF;
  localparam coord_t QMIN = 32'sh8000_0000;

  // after reset the direction is zero, so every triangle misses
  coord_t zero_rows [5][9] = '{
    '{QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMAX, QMIN, QMAX},
    '{QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{-1, -1, -1, 0, 0, 0, 1, 1, 1},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, QMAX}
  };

  // ray from the origin along +z, one unit per step
  coord_t ray_rows [9][9] = '{
    '{-Q_ONE, -Q_ONE, 5*Q_ONE, 2*Q_ONE, -Q_ONE, 5*Q_ONE, -Q_ONE, 2*Q_ONE, 5*Q_ONE},
    '{0, 0, 3*Q_ONE, Q_ONE, 0, 3*Q_ONE, 0, Q_ONE, 3*Q_ONE},        // on a vertex
    '{-Q_ONE, 0, 2*Q_ONE, Q_ONE, 0, 2*Q_ONE, 0, Q_ONE, 2*Q_ONE},   // on an edge
    '{Q_ONE, Q_ONE, 2*Q_ONE, 2*Q_ONE, Q_ONE, 2*Q_ONE, Q_ONE, 2*Q_ONE, 2*Q_ONE},
    '{-Q_ONE, -Q_ONE, -2*Q_ONE, 2*Q_ONE, -Q_ONE, -2*Q_ONE,         // behind
      -Q_ONE, 2*Q_ONE, -2*Q_ONE},
    '{Q_ONE, 0, Q_ONE, Q_ONE, 0, Q_ONE, 0, Q_ONE, Q_ONE},          // zero area
    '{0, -Q_ONE, 0, 0, Q_ONE, 0, 0, 0, Q_ONE},                     // parallel
    '{-Q_ONE, -Q_ONE, -32768, 2*Q_ONE, -Q_ONE, -32768,             // slightly behind
      -Q_ONE, 2*Q_ONE, -32768},
    '{64880, -130416, 2*Q_ONE, 64880+Q_ONE, -130416, 2*Q_ONE,      // v beyond range
      64880, -130416+Q_ONE, 2*Q_ONE}
  };

  initial begin
    tri_t tv;
    int per_phase;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.v0_x = '0; in_ch.v0_y = '0; in_ch.v0_z = '0;
    in_ch.v1_x = '0; in_ch.v1_y = '0; in_ch.v1_z = '0;
    in_ch.v2_x = '0; in_ch.v2_y = '0; in_ch.v2_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ORIGIN_X;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    foreach (ray_org[i]) begin
      ray_org[i] = '0;
      ray_dir[i] = '0;
    end
    ray_tol = '0;
    n_mismatch = 0; n_orphan = 0; n_results = 0; n_hits = 0; n_sent = 0;
    idle_cycles = 0; held_once = 1'b0;
    tx_busy_gaps = 1'b1; rx_busy_gaps = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of the ray: misses with all-zero fields
    foreach (zero_rows[r]) begin
      tv = zero_rows[r];
      send_tri(tv, 1'b1);
    end
    drain();

    // axis ray, exact tolerance then widest tolerance
    load_ray(0, 0, 0, 0, 0, Q_ONE, 0);
    foreach (ray_rows[r]) begin
      tv = ray_rows[r];
      send_tri(tv, 1'b0);
    end
    drain();
    load_ray(0, 0, 0, 0, 0, Q_ONE, 16'hFFFF);
    foreach (ray_rows[r]) begin
      tv = ray_rows[r];
      send_tri(tv, 1'b0);
    end
    drain();

    // random phases; two of them with the registers at their extremes
    per_phase = N_RAND / N_PHASES;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      tx_busy_gaps = (ph % 3 != 1);
      rx_busy_gaps = (ph % 4 != 2);
      if (ph == 4)
        load_ray(QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, 16'hFFFF);
      else if (ph == 5)
        load_ray(QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, 0);
      else if (ph == 7)
        load_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        load_ray($urandom_range(0, 1 << 21) - (1 << 20),
                 $urandom_range(0, 1 << 21) - (1 << 20),
                 $urandom_range(0, 1 << 21) - (1 << 20),
                 $urandom_range(0, 1 << 18) - (1 << 17),
                 $urandom_range(0, 1 << 18) - (1 << 17),
                 $urandom_range(0, 1 << 18) - (1 << 17),
                 (ph == 0) ? 0 : $urandom_range(0, 16'hFFFF));
      repeat (per_phase) begin
        make_tri(tv);
        send_tri(tv, 1'b0);
      end
      drain();
    end

    $display("Sent %0d triangles over %0d ray settings; %0d results, %0d hits.",
             n_sent, N_PHASES + 3, n_results, n_hits);
    $display("Mismatches %0d, unexpected results %0d, still expected %0d.",
             n_mismatch, n_orphan, pending_isects.size());
    if (n_mismatch == 0 && n_orphan == 0 && pending_isects.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
